// File: rtl/core/tldr_pkg.sv
// shared types, constants and helpers for the thick line depth rasterizer
`default_nettype none

package tldr_pkg;

    // framebuffer geometry
    localparam int FB_WIDTH  = 256;
    localparam int FB_HEIGHT = 256;
    localparam int FB_PIXELS = FB_WIDTH * FB_HEIGHT;
    localparam int FB_ADDR_W = $clog2(FB_PIXELS);

    // divider sizing
    localparam int DIV_N_W   = 50;
    localparam int DIV_D_W   = 34;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // screen coordinate clamp and depth constants
    localparam logic signed [15:0] COORD_MIN  = -16'sd8192;
    localparam logic signed [15:0] COORD_MAX  = 16'sd8191;
    localparam logic signed [31:0] DEPTH_FAR  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DEPTH_NEAR = 32'sh8000_0000;
    localparam logic signed [50:0] DEPTH_BIAS = 51'sd655;

    // operations
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VP_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VP_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_H = 3'd3;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_READ, S_CM1, S_CM2, S_CDIV, S_CWAIT, S_DEGEN,
        S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_SQ5, S_SQ6, S_SQ7,
        S_PIX, S_PMUL, S_PWAIT, S_STEP, S_SY_M, S_SY_T, S_AEND,
        S_BBEG, S_SX_M, S_SX_T, S_BEND, S_FIN, S_DONE
    } st_t;

    typedef struct packed {
        logic                       start;
        logic signed [DIV_N_W-1:0]  dividend;
        logic signed [DIV_D_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic signed [DIV_N_W-1:0]  quotient;
    } div_rsp_t;

    // pixel lies inside the framebuffer
    function automatic logic inside_fb(input logic signed [15:0] px,
                                       input logic signed [15:0] py);
        inside_fb = !px[15] && (px[14:0] < 15'(FB_WIDTH))
                 && !py[15] && (py[14:0] < 15'(FB_HEIGHT));
    endfunction

    // linear store address of an inside pixel
    function automatic logic [FB_ADDR_W-1:0] pix_addr(input logic signed [15:0] px,
                                                      input logic signed [15:0] py);
        logic [31:0] a;
        a = 32'(py[14:0]) * 32'(FB_WIDTH) + 32'(px[14:0]);
        pix_addr = a[FB_ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tldr_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none

module tldr_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tldr_pkg::div_req_t req,
    output tldr_pkg::div_rsp_t      rsp
);
    import tldr_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]    rem_reg, rem_next;
    logic [DIV_N_W-1:0]    quo_reg, quo_next;
    logic [DIV_D_W-1:0]    den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic [DIV_D_W:0]      trial;
    logic [DIV_D_W:0]      diff;
    logic                  fits;

    // restoring step and start loading
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_N_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend[DIV_N_W-1] ? DIV_N_W'(-req.dividend)
                                                : DIV_N_W'(req.dividend);
            den_next  = req.divisor[DIV_D_W-1] ? DIV_D_W'(-req.divisor)
                                               : DIV_D_W'(req.divisor);
            neg_next  = req.dividend[DIV_N_W-1] ^ req.divisor[DIV_D_W-1];
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                busy_next = 1'b0;
            rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // result with sign restored
    always_comb
    begin
        rsp.busy     = busy_reg;
        rsp.done     = done_reg;
        rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    end

endmodule

`default_nettype wire

// File: rtl/core/thick_line_depth_raster.sv
// thick line rasterizer with depth test over on-chip colour and depth stores
// Reset: a clearing pass fills every store address (colour 0, depth far);
//   no item is taken meanwhile, configuration writes are.
// Read item: the stores are read, the result is latched in S_READ and handed on in S_DONE.
// Draw item: four endpoint divides through the shared divider, then setup, then per
//   centre pixel a framebuffer check and, inside, one depth divide, plus a test per
//   side pixel.
// One item at a time; the next is taken once the result sits in the output register.
`default_nettype none

module thick_line_depth_raster (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] start_z,
    input  wire logic signed [31:0] start_w,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic signed [31:0] end_z,
    input  wire logic signed [31:0] end_w,
    input  wire logic [31:0]        line_color,
    input  wire logic [15:0]        line_thickness,
    input  wire logic [15:0]        pixel_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             pixel_color,
    output logic signed [31:0]      pixel_depth,
    output logic [15:0]             pixels_written,
    output logic                    degenerate
);
    import tldr_pkg::*;

    // control state
    st_t                   state_reg, state_next;
    logic [1:0]            ci_reg, ci_next;
    logic [FB_ADDR_W-1:0]  clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [11:0]           vx_reg, vy_reg;
    logic [12:0]           vw_reg, vh_reg;

    // latched item
    logic signed [31:0] c0x_reg, c0x_next, c0y_reg, c0y_next;
    logic signed [31:0] z0_reg, z0_next, w0_reg, w0_next;
    logic signed [31:0] c1x_reg, c1x_next, c1y_reg, c1y_next;
    logic signed [31:0] z1_reg, z1_next, w1_reg, w1_next;
    logic [31:0]        color_reg, color_next;
    logic [16:0]        k_reg, k_next;

    // walk state
    logic signed [15:0] x0_reg, x0_next, y0_reg, y0_next, x1_reg, x1_next, y1_reg, y1_next;
    logic signed [15:0] x_reg, x_next, y_reg, y_next, x2_reg, x2_next, y2_reg, y2_next;
    logic signed [15:0] dx_reg, dx_next, dy_reg, dy_next;
    logic               negx_reg, negx_next, negy_reg, negy_next, majx_reg, majx_next;
    logic signed [17:0] err_reg, err_next, olderr_reg, olderr_next;
    logic signed [23:0] e_reg, e_next;
    logic [29:0]        d2_reg, d2_next;
    logic [33:0]        k2_reg, k2_next;
    logic [63:0]        d2k2_reg, d2k2_next;
    logic signed [58:0] tmp_reg, tmp_next;
    logic signed [31:0] dep_reg, dep_next;
    logic               draw_reg, draw_next;
    logic [15:0]        cnt_reg, cnt_next;

    // result
    logic [31:0]        res_color_reg, res_color_next;
    logic signed [31:0] res_depth_reg, res_depth_next;
    logic [15:0]        res_count_reg, res_count_next;
    logic               res_degen_reg, res_degen_next;
    logic [31:0]        oc_reg, oc_next;
    logic signed [31:0] od_reg, od_next;
    logic [15:0]        on_reg, on_next;
    logic               og_reg, og_next;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [58:0] mul_reg;

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // stores
    logic [31:0]          color_mem [FB_PIXELS];
    logic [31:0]          depth_mem [FB_PIXELS];
    logic                 mem_we, mem_re;
    logic [FB_ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]          mem_wcolor, mem_wdepth;
    logic [31:0]          rd_color_reg, rd_depth_reg;

    // helpers
    logic signed [31:0] c_sel, w_sel;
    logic [11:0]        vo_sel;
    logic [12:0]        vs_sel;
    logic [14:0]        offs;
    logic signed [58:0] num_sum;
    logic signed [15:0] q_sat;
    logic signed [50:0] dep_w;
    logic signed [31:0] dep_sat;
    logic signed [15:0] dxv, dyv, pdiff, pden, step_v;
    logic signed [19:0] two_err;
    logic               within_ok;
    logic               put;
    logic signed [15:0] put_x, put_y;

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign pixel_color    = oc_reg;
    assign pixel_depth    = od_reg;
    assign pixels_written = on_reg;
    assign degenerate     = og_reg;

    tldr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // endpoint component selection for the coordinate pass
    always_comb
    begin
        case (ci_reg)
            2'd0:    c_sel = c0x_reg;
            2'd1:    c_sel = c0y_reg;
            2'd2:    c_sel = c1x_reg;
            default: c_sel = c1y_reg;
        endcase
        w_sel  = ci_reg[1] ? w1_reg : w0_reg;
        vo_sel = ci_reg[0] ? vy_reg : vx_reg;
        vs_sel = ci_reg[0] ? vh_reg : vw_reg;
        offs   = 15'({vo_sel, 1'b0}) + 15'(vs_sel);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ci_next        = ci_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        c0x_next = c0x_reg; c0y_next = c0y_reg; z0_next = z0_reg; w0_next = w0_reg;
        c1x_next = c1x_reg; c1y_next = c1y_reg; z1_next = z1_reg; w1_next = w1_reg;
        color_next = color_reg; k_next = k_reg;
        x0_next = x0_reg; y0_next = y0_reg; x1_next = x1_reg; y1_next = y1_reg;
        x_next = x_reg; y_next = y_reg; x2_next = x2_reg; y2_next = y2_reg;
        dx_next = dx_reg; dy_next = dy_reg;
        negx_next = negx_reg; negy_next = negy_reg; majx_next = majx_reg;
        err_next = err_reg; olderr_next = olderr_reg; e_next = e_reg;
        d2_next = d2_reg; k2_next = k2_reg; d2k2_next = d2k2_reg; tmp_next = tmp_reg;
        dep_next = dep_reg; draw_next = draw_reg; cnt_next = cnt_reg;
        res_color_next = res_color_reg; res_depth_next = res_depth_reg;
        res_count_next = res_count_reg; res_degen_next = res_degen_reg;
        oc_next = oc_reg; od_next = od_reg; on_next = on_reg; og_next = og_reg;

        mul_a      = '0;
        mul_b      = '0;
        div_req    = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = '0;
        mem_raddr  = '0;
        mem_wcolor = color_reg;
        mem_wdepth = dep_reg;
        put        = 1'b0;
        put_x      = x_reg;
        put_y      = y_reg;

        num_sum = tmp_reg + mul_reg;
        if (div_rsp.quotient < -50'sd8192)
            q_sat = COORD_MIN;
        else if (div_rsp.quotient > 50'sd8191)
            q_sat = COORD_MAX;
        else
            q_sat = div_rsp.quotient[15:0];
        dep_w = 51'(z0_reg) + 51'(div_rsp.quotient) - DEPTH_BIAS;
        if (dep_w > 51'(DEPTH_FAR))
            dep_sat = DEPTH_FAR;
        else if (dep_w < 51'(DEPTH_NEAR))
            dep_sat = DEPTH_NEAR;
        else
            dep_sat = dep_w[31:0];
        dxv       = (x1_reg - x0_reg) < 0 ? x0_reg - x1_reg : x1_reg - x0_reg;
        dyv       = (y1_reg - y0_reg) < 0 ? y0_reg - y1_reg : y1_reg - y0_reg;
        pdiff     = majx_reg ? x_reg - x0_reg : y_reg - y0_reg;
        pden      = majx_reg ? x1_reg - x0_reg : y1_reg - y0_reg;
        two_err   = $signed({err_reg[17], err_reg, 1'b0});
        within_ok = e_reg[23] || ({mul_reg[45:0], 18'b0} < d2k2_reg);
        step_v    = 16'sd0;

        // output register drains independently
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            // fill the stores with their reset contents
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = clr_reg;
                mem_wcolor = '0;
                mem_wdepth = DEPTH_FAR;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == FB_ADDR_W'(FB_PIXELS - 1))
                    state_next = S_IDLE;
            end
            // take a beat
            S_IDLE:
            begin
                if (in_valid)
                begin
                    c0x_next = start_x; c0y_next = start_y; z0_next = start_z; w0_next = start_w;
                    c1x_next = end_x;   c1y_next = end_y;   z1_next = end_z;   w1_next = end_w;
                    color_next     = line_color;
                    k_next         = 17'(line_thickness) + 17'd256;
                    ci_next        = '0;
                    res_color_next = '0;
                    res_depth_next = '0;
                    res_count_next = '0;
                    res_degen_next = 1'b0;
                    if (operation == OP_READ)
                    begin
                        if (32'(pixel_index) < 32'(FB_PIXELS))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = FB_ADDR_W'(pixel_index);
                            state_next = S_READ;
                        end
                        else
                            state_next = S_DONE;
                    end
                    else if (start_w == 32'sd0 || end_w == 32'sd0)
                        state_next = S_DONE;
                    else
                        state_next = S_CM1;
                end
            end
            S_READ:
            begin
                res_color_next = rd_color_reg;
                res_depth_next = rd_depth_reg;
                state_next     = S_DONE;
            end
            // screen coordinate: (vs*c + (2*vo+vs)*w) / (2*w)
            S_CM1:
            begin
                mul_a      = 34'(c_sel);
                mul_b      = $signed({12'b0, vs_sel});
                state_next = S_CM2;
            end
            S_CM2:
            begin
                tmp_next   = mul_reg;
                mul_a      = 34'(w_sel);
                mul_b      = $signed({10'b0, offs});
                state_next = S_CDIV;
            end
            S_CDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_sum[DIV_N_W-1:0];
                div_req.divisor  = $signed({w_sel[31], w_sel, 1'b0});
                state_next       = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (div_rsp.done)
                begin
                    case (ci_reg)
                        2'd0:    x0_next = q_sat;
                        2'd1:    y0_next = q_sat;
                        2'd2:    x1_next = q_sat;
                        default: y1_next = q_sat;
                    endcase
                    ci_next    = ci_reg + 1'b1;
                    state_next = (ci_reg == 2'd3) ? S_DEGEN : S_CM1;
                end
            end
            // endpoint check and walk setup
            S_DEGEN:
            begin
                if (x0_reg == x1_reg && y0_reg == y1_reg)
                begin
                    res_degen_next = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    dx_next    = dxv;
                    dy_next    = dyv;
                    negx_next  = !(x0_reg < x1_reg);
                    negy_next  = !(y0_reg < y1_reg);
                    majx_next  = dxv > dyv;
                    err_next   = 18'(dxv) - 18'(dyv);
                    x_next     = x0_reg;
                    y_next     = y0_reg;
                    cnt_next   = '0;
                    state_next = S_SQ1;
                end
            end
            // d2 = dx^2 + dy^2, then d2 * k^2 in two halves
            S_SQ1:
            begin
                mul_a      = 34'(dx_reg);
                mul_b      = 25'(dx_reg);
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                tmp_next   = mul_reg;
                mul_a      = 34'(dy_reg);
                mul_b      = 25'(dy_reg);
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                d2_next    = tmp_reg[29:0] + mul_reg[29:0];
                mul_a      = $signed({17'b0, k_reg});
                mul_b      = $signed({8'b0, k_reg});
                state_next = S_SQ4;
            end
            S_SQ4:
            begin
                k2_next    = mul_reg[33:0];
                state_next = S_SQ5;
            end
            S_SQ5:
            begin
                mul_a      = $signed({4'b0, d2_reg});
                mul_b      = $signed({8'b0, k2_reg[16:0]});
                state_next = S_SQ6;
            end
            S_SQ6:
            begin
                tmp_next   = mul_reg;
                mul_a      = $signed({4'b0, d2_reg});
                mul_b      = $signed({8'b0, k2_reg[33:17]});
                state_next = S_SQ7;
            end
            S_SQ7:
            begin
                d2k2_next  = 64'(tmp_reg[47:0]) + {mul_reg[46:0], 17'b0};
                state_next = S_PIX;
            end
            // centre pixel: depth product and stored depth read
            S_PIX:
            begin
                draw_next = 1'b0;
                if (inside_fb(x_reg, y_reg))
                begin
                    mul_a      = 34'(z1_reg) - 34'(z0_reg);
                    mul_b      = 25'(pdiff);
                    mem_re     = 1'b1;
                    mem_raddr  = pix_addr(x_reg, y_reg);
                    state_next = S_PMUL;
                end
                else
                    state_next = S_STEP;
            end
            S_PMUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_reg[DIV_N_W-1:0];
                div_req.divisor  = 34'(pden);
                state_next       = S_PWAIT;
            end
            // depth test and centre write
            S_PWAIT:
            begin
                if (div_rsp.done)
                begin
                    dep_next = dep_sat;
                    if (dep_sat < $signed(rd_depth_reg))
                    begin
                        draw_next  = 1'b1;
                        put        = 1'b1;
                        mem_wdepth = dep_sat;
                    end
                    state_next = S_STEP;
                end
            end
            // x half step
            S_STEP:
            begin
                olderr_next = err_reg;
                x2_next     = x_reg;
                if (two_err >= -(20'(dx_reg)))
                begin
                    if (draw_reg)
                    begin
                        e_next     = 24'(err_reg) + 24'(dy_reg);
                        y2_next    = y_reg;
                        state_next = S_SY_M;
                    end
                    else
                        state_next = S_AEND;
                end
                else
                    state_next = S_BBEG;
            end
            S_SY_M:
            begin
                mul_a      = 34'(e_reg);
                mul_b      = 25'(e_reg);
                state_next = S_SY_T;
            end
            // side pixels along y
            S_SY_T:
            begin
                if (within_ok && (y1_reg != y2_reg || dx_reg > dy_reg))
                begin
                    step_v     = negy_reg ? y2_reg - 16'sd1 : y2_reg + 16'sd1;
                    y2_next    = step_v;
                    put        = 1'b1;
                    put_x      = x_reg;
                    put_y      = step_v;
                    e_next     = e_reg + 24'(dx_reg);
                    state_next = S_SY_M;
                end
                else
                    state_next = S_AEND;
            end
            S_AEND:
            begin
                if (x_reg == x1_reg)
                    state_next = S_FIN;
                else
                begin
                    err_next   = err_reg - 18'(dy_reg);
                    x_next     = negx_reg ? x_reg - 16'sd1 : x_reg + 16'sd1;
                    state_next = S_BBEG;
                end
            end
            // y half step
            S_BBEG:
            begin
                if ($signed({olderr_reg[17], olderr_reg, 1'b0}) <= 20'(dy_reg))
                begin
                    if (draw_reg)
                    begin
                        e_next     = 24'(dx_reg) - 24'(olderr_reg);
                        state_next = S_SX_M;
                    end
                    else
                        state_next = S_BEND;
                end
                else
                    state_next = S_PIX;
            end
            S_SX_M:
            begin
                mul_a      = 34'(e_reg);
                mul_b      = 25'(e_reg);
                state_next = S_SX_T;
            end
            // side pixels along x
            S_SX_T:
            begin
                if (within_ok && (x1_reg != x2_reg || dx_reg < dy_reg))
                begin
                    step_v     = negx_reg ? x2_reg - 16'sd1 : x2_reg + 16'sd1;
                    x2_next    = step_v;
                    put        = 1'b1;
                    put_x      = step_v;
                    put_y      = y_reg;
                    e_next     = e_reg + 24'(dy_reg);
                    state_next = S_SX_M;
                end
                else
                    state_next = S_BEND;
            end
            S_BEND:
            begin
                if (y_reg == y1_reg)
                    state_next = S_FIN;
                else
                begin
                    err_next   = err_reg + 18'(dx_reg);
                    y_next     = negy_reg ? y_reg - 16'sd1 : y_reg + 16'sd1;
                    state_next = S_PIX;
                end
            end
            S_FIN:
            begin
                res_count_next = cnt_reg;
                state_next     = S_DONE;
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    oc_next        = res_color_reg;
                    od_next        = res_depth_reg;
                    on_next        = res_count_reg;
                    og_next        = res_degen_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pixel write with framebuffer clip and saturating count
        if (put && inside_fb(put_x, put_y))
        begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr(put_x, put_y);
            if (cnt_reg != 16'hFFFF)
                cnt_next = cnt_reg + 16'd1;
        end
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ci_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            vx_reg        <= 12'd0;
            vy_reg        <= 12'd0;
            vw_reg        <= 13'd256;
            vh_reg        <= 13'd256;
        end
        else
        begin
            state_reg     <= state_next;
            ci_reg        <= ci_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_VP_X: vx_reg <= cfg_data[11:0];
                    REG_VP_Y: vy_reg <= cfg_data[11:0];
                    REG_VP_W: vw_reg <= cfg_data[12:0];
                    REG_VP_H: vh_reg <= cfg_data[12:0];
                    default:  ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        c0x_reg <= c0x_next; c0y_reg <= c0y_next; z0_reg <= z0_next; w0_reg <= w0_next;
        c1x_reg <= c1x_next; c1y_reg <= c1y_next; z1_reg <= z1_next; w1_reg <= w1_next;
        color_reg <= color_next; k_reg <= k_next;
        x0_reg <= x0_next; y0_reg <= y0_next; x1_reg <= x1_next; y1_reg <= y1_next;
        x_reg <= x_next; y_reg <= y_next; x2_reg <= x2_next; y2_reg <= y2_next;
        dx_reg <= dx_next; dy_reg <= dy_next;
        negx_reg <= negx_next; negy_reg <= negy_next; majx_reg <= majx_next;
        err_reg <= err_next; olderr_reg <= olderr_next; e_reg <= e_next;
        d2_reg <= d2_next; k2_reg <= k2_next; d2k2_reg <= d2k2_next; tmp_reg <= tmp_next;
        dep_reg <= dep_next; draw_reg <= draw_next; cnt_reg <= cnt_next;
        res_color_reg <= res_color_next; res_depth_reg <= res_depth_next;
        res_count_reg <= res_count_next; res_degen_reg <= res_degen_next;
        oc_reg <= oc_next; od_reg <= od_next; on_reg <= on_next; og_reg <= og_next;
    end

    // colour and depth stores
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[mem_waddr] <= mem_wcolor;
            depth_mem[mem_waddr] <= mem_wdepth;
        end
        if (mem_re)
        begin
            rd_color_reg <= color_mem[mem_raddr];
            rd_depth_reg <= depth_mem[mem_raddr];
        end
    end

    // stores are never written while idle, reading or presenting a result
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != S_IDLE && state_reg != S_READ && state_reg != S_DONE))
        else $error("store write outside a draw or clear");

    // divider is only started when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // an accepted beat leaves idle at once
    a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("still ready after accepting a beat");

    // a new result only comes from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done state");

endmodule

`default_nettype wire
